>>> hdl/imm_pkg.sv
// Shared types and constants for the integer matrix multiplier.
// Used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package imm_pkg;

  localparam int unsigned MaxDim    = 8;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned DimW      = 4;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned AddrW     = 2 * IdxW;
  localparam int unsigned Depth     = MaxDim * MaxDim;

  typedef logic [DimW-1:0]      dim_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam dim_t DimReset = dim_t'(MaxDim);

  // Per-term tag that travels down the datapath with the read data
  typedef struct packed {
    logic first;  // first term of a dot product
    logic lastk;  // last term of a dot product
    logic zero;   // empty dot product, term counts as zero
    idx_t row;
    idx_t col;
    logic last;   // final element of the run
  } tag_t;

  typedef struct packed {
    logic  we_a;
    logic  we_b;
    addr_t waddr;
    word_t wdata;
    logic  rd_en;
    addr_t raddr_a;
    addr_t raddr_b;
    tag_t  tag;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  function automatic dim_t clamp_dim(dim_t v);
    return (v > DimReset) ? DimReset : v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/imm_if.sv
// Request channels of the integer matrix multiplier: input, result and
// configuration write. Depends on imm_pkg.
`default_nettype none

interface imm_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [imm_pkg::IdxW-1:0]         row_index;
  logic [imm_pkg::IdxW-1:0]         col_index;
  logic signed [imm_pkg::WordWidth-1:0] element_value;

  modport source(output valid, output mode, output row_index, output col_index,
                 output element_value, input ready);
  modport sink(input valid, input mode, input row_index, input col_index,
               input element_value, output ready);
endinterface

interface imm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [imm_pkg::WordWidth-1:0] product_value;
  logic [imm_pkg::IdxW-1:0]         out_row;
  logic [imm_pkg::IdxW-1:0]         out_col;
  logic                             last;

  modport source(output valid, output product_value, output out_row, output out_col,
                 output last, input ready);
  modport sink(input valid, input product_value, input out_row, input out_col,
               input last, output ready);
endinterface

interface imm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               index;
  logic [imm_pkg::DimW-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/integer_matrix_multiply.sv
// Integer matrix multiplier.
// Channels: in_i takes load and compute requests, cfg_i writes the sizes
// rows_a, inner_dim and cols_b (index 0..2, values above 8 act as 8),
// out_o returns product elements row-major with row, column and last flag.
// A load request (write of one element of A or B) is taken while idle;
// loads outside the configured sizes are dropped. A compute request walks
// rows_a x cols_b elements; each element issues inner_dim store reads
// through the one shared multiplier, then drains the read, multiply and
// accumulate stages and hands over the result before the next one starts.
// New requests are taken only between runs. A stalled sink holds the
// current result and pauses the walk; nothing is lost.
// Reset sets all sizes to 8 and empties the pipeline; store contents are
// undefined until loaded. cfg_i is always ready; write it only while idle.
// Depends on imm_pkg, imm_if, imm_ctrl and imm_dp.
`default_nettype none

module integer_matrix_multiply (
  input  logic       clk_i,
  input  logic       rst_ni,
  imm_in_if.sink     in_i,
  imm_cfg_if.sink    cfg_i,
  imm_out_if.source  out_o
);

  imm_pkg::cmd_t  cmd;
  imm_pkg::stat_t stat;

  imm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  imm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

>>> hdl/imm_ctrl.sv
// Controller: size registers, load decode and the row/column/term walk.
// Depends on imm_pkg and the imm_in_if / imm_cfg_if interfaces.
`default_nettype none

module imm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  imm_in_if.sink          in_i,
  imm_cfg_if.sink         cfg_i,
  input  imm_pkg::stat_t  stat_i,
  output imm_pkg::cmd_t   cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;
  imm_pkg::dim_t rows_a_q, inner_dim_q, cols_b_q;
  imm_pkg::idx_t r_q, r_d, c_q, c_d, i_q, i_d;
  imm_pkg::dim_t ra, kd, cb;
  logic in_acc, term_last, col_last, elem_last;

  assign ra = imm_pkg::clamp_dim(rows_a_q);
  assign kd = imm_pkg::clamp_dim(inner_dim_q);
  assign cb = imm_pkg::clamp_dim(cols_b_q);

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  assign term_last = (kd == '0) || (imm_pkg::dim_t'(i_q) + 1'b1 == kd);
  assign col_last  = (imm_pkg::dim_t'(c_q) + 1'b1 == cb);
  assign elem_last = col_last && (imm_pkg::dim_t'(r_q) + 1'b1 == ra);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= imm_pkg::DimReset;
      inner_dim_q <= imm_pkg::DimReset;
      cols_b_q    <= imm_pkg::DimReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        imm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_i.data;
        imm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_i.data;
        imm_pkg::REG_COLS_B:    cols_b_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    i_d     = i_q;

    cmd_o           = '0;
    cmd_o.waddr     = {in_i.row_index, in_i.col_index};
    cmd_o.wdata     = imm_pkg::word_t'(in_i.element_value);
    cmd_o.raddr_a   = {r_q, i_q};
    cmd_o.raddr_b   = {i_q, c_q};
    cmd_o.tag.first = (i_q == '0);
    cmd_o.tag.lastk = term_last;
    cmd_o.tag.zero  = (kd == '0);
    cmd_o.tag.row   = r_q;
    cmd_o.tag.col   = c_q;
    cmd_o.tag.last  = elem_last;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (imm_pkg::mode_e'(in_i.mode))
            imm_pkg::MODE_LOAD_A: begin
              cmd_o.we_a = (imm_pkg::dim_t'(in_i.row_index) < ra) &&
                           (imm_pkg::dim_t'(in_i.col_index) < kd);
            end
            imm_pkg::MODE_LOAD_B: begin
              cmd_o.we_b = (imm_pkg::dim_t'(in_i.row_index) < kd) &&
                           (imm_pkg::dim_t'(in_i.col_index) < cb);
            end
            imm_pkg::MODE_COMPUTE: begin
              if (ra != '0 && cb != '0) begin
                state_d = StIssue;
                r_d     = '0;
                c_d     = '0;
                i_d     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      StIssue: begin
        cmd_o.rd_en = 1'b1;
        if (term_last) begin
          state_d = StDrain;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      StDrain: begin
        // next element starts once the previous result has been taken
        if (!stat_i.busy) begin
          if (elem_last) begin
            state_d = StIdle;
          end else begin
            state_d = StIssue;
            i_d     = '0;
            if (col_last) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      r_q     <= '0;
      c_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      i_q     <= i_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/imm_dp.sv
// Datapath: the two matrix stores, multiplier, accumulator and result
// register. Depends on imm_pkg and the imm_out_if interface.
`default_nettype none

module imm_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  imm_pkg::cmd_t   cmd_i,
  output imm_pkg::stat_t  stat_o,
  imm_out_if.source       out_o
);

  imm_pkg::word_t mem_a [imm_pkg::Depth];
  imm_pkg::word_t mem_b [imm_pkg::Depth];

  imm_pkg::word_t rd_a_q, rd_b_q, prod_q, acc_q, acc_d, prod_d;
  imm_pkg::tag_t  s1_tag_q, s2_tag_q;
  logic           s1_v_q, s2_v_q, out_v_q;
  imm_pkg::word_t out_val_q;
  imm_pkg::idx_t  out_row_q, out_col_q;
  logic           out_last_q;
  imm_pkg::word_t prod_lo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we_a) begin
      mem_a[cmd_i.waddr] <= cmd_i.wdata;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_a[cmd_i.raddr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we_b) begin
      mem_b[cmd_i.waddr] <= cmd_i.wdata;
    end
    if (cmd_i.rd_en) begin
      rd_b_q <= mem_b[cmd_i.raddr_b];
    end
  end

  // only the low word of the product matters under wrap-around
  assign prod_lo = rd_a_q * rd_b_q;
  assign prod_d  = s1_tag_q.zero ? '0 : prod_lo;
  assign acc_d   = s2_tag_q.first ? prod_q : acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.rd_en;
      s2_v_q <= s1_v_q;
      if (s2_v_q && s2_tag_q.lastk) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= cmd_i.tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= prod_d;
    if (s2_v_q) begin
      acc_q <= acc_d;
    end
    if (s2_v_q && s2_tag_q.lastk) begin
      out_val_q  <= acc_d;
      out_row_q  <= s2_tag_q.row;
      out_col_q  <= s2_tag_q.col;
      out_last_q <= s2_tag_q.last;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.product_value = $signed(out_val_q);
  assign out_o.out_row       = out_row_q;
  assign out_o.out_col       = out_col_q;
  assign out_o.last          = out_last_q;

  assign stat_o.busy = s1_v_q || s2_v_q || out_v_q;

endmodule

`default_nettype wire

>>> hdl/imm_chk.sv
// Port-level checks of the integer matrix multiplier, bound to the top.
// Depends on imm_pkg and integer_matrix_multiply.
`default_nettype none

module imm_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_last_i,
  input logic [imm_pkg::WordWidth-1:0] out_value_i,
  input logic [imm_pkg::IdxW-1:0]      out_row_i,
  input logic [imm_pkg::IdxW-1:0]      out_col_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
      $stable(out_row_i) && $stable(out_col_i) && $stable(out_last_i))
    else $error("stalled result changed");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("result pending while taking requests");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_i |=> ##1 in_ready_i)
    else $error("not idle after final element");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_i |=> !in_ready_i && !out_valid_i)
    else $error("run ended early or result repeated");

endmodule

bind integer_matrix_multiply imm_chk u_imm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last),
  .out_value_i (out_o.product_value),
  .out_row_i   (out_o.out_row),
  .out_col_i   (out_o.out_col)
);

`default_nettype wire
